// ===== rtl/dcs_pkg.sv =====
package dcs_pkg;

    // Shared multiplier geometry
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;

    // Stream payload widths
    localparam int CMD_W   = 8;
    localparam int TDATA_W = 2 * CMD_W;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Reciprocal of 127 in Q16, slightly low so one upward correction suffices
    localparam logic [MUL_W-1:0] RECIP_127 = MUL_W'(516);
    localparam logic [7:0]       CMD_MAX   = 8'd127;

    // Register reset values
    localparam logic       RST_DRIVE_MODE  = 1'b0;
    localparam logic [6:0] RST_DEADZONE    = 7'd5;
    localparam logic       RST_CURVE_EN    = 1'b1;
    localparam logic [8:0] RST_CURVE_BLEND = 9'd256;
    localparam logic [9:0] RST_SENS        = 10'd256;
    localparam logic [6:0] RST_REV_BAND    = 7'd10;
    localparam logic [7:0] RST_SLEW_STEP   = 8'd15;
    localparam logic       RST_STOP_REV    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRIVE_MODE   = 3'd0,
        REG_DEADZONE     = 3'd1,
        REG_CURVE_ENABLE = 3'd2,
        REG_CURVE_BLEND  = 3'd3,
        REG_SENSITIVITY  = 3'd4,
        REG_REV_BAND     = 3'd5,
        REG_SLEW_STEP    = 3'd6,
        REG_STOP_ON_REV  = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRV_P,
        ST_CRV_T,
        ST_CRV_N,
        ST_CRV_Q,
        ST_CRV_C,
        ST_GAIN_L,
        ST_GAIN_R,
        ST_CLAMP_R,
        ST_SLEW
    } t_state;

    // Request to the shared multiplier
    typedef struct packed {
        logic                    en;
        logic signed [MUL_W-1:0] op_a;
        logic signed [MUL_W-1:0] op_b;
    } t_mul_req;

    // Settings seen by the slew limiter
    typedef struct packed {
        logic [6:0] band;
        logic [7:0] step;
        logic       stop;
    } t_slew_cfg;

endpackage

// ===== rtl/dcs_mul.sv =====
module dcs_mul (
    input  logic                                  i_clk,
    input  dcs_pkg::t_mul_req                     i_req,
    output logic signed [dcs_pkg::PROD_W-1:0]     o_prod
);
    import dcs_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // Signed multiply, product registered and held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.op_a * i_req.op_b;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/dcs_slew.sv =====
module dcs_slew (
    input  dcs_pkg::t_slew_cfg  i_cfg,
    input  logic signed [7:0]   i_cur,
    input  logic signed [7:0]   i_tgt,
    output logic signed [7:0]   o_next
);
    import dcs_pkg::*;

    logic signed [9:0] cur;
    logic signed [9:0] tgt;
    logic signed [9:0] delta;
    logic signed [9:0] band;
    logic signed [9:0] step;
    logic signed [9:0] cur_mag;
    logic signed [9:0] dlt_mag;
    logic signed [9:0] st;
    logic              rev;
    logic signed [9:0] res;

    assign cur     = 10'(i_cur);
    assign tgt     = 10'(i_tgt);
    assign delta   = tgt - cur;
    assign band    = $signed({3'b000, i_cfg.band});
    assign step    = $signed({2'b00, i_cfg.step});
    assign cur_mag = cur[9] ? -cur : cur;
    assign dlt_mag = delta[9] ? -delta : delta;
    assign st      = (step < cur_mag) ? step : cur_mag;
    assign rev     = ((cur > band) && (tgt < -band)) || ((cur < -band) && (tgt > band));

    // Small change passes; with stop set a reversal ramps toward zero; else move to target, limited by step
    always_comb begin
        if (dlt_mag <= 10'sd1) begin
            res = tgt;
        end else if (rev && i_cfg.stop) begin
            res = (cur > 10'sd0) ? (cur - st) : (cur + st);
        end else if (dlt_mag <= step) begin
            res = tgt;
        end else begin
            res = delta[9] ? (cur - step) : (cur + step);
        end
    end

    assign o_next = res[7:0];

endmodule

// ===== rtl/drive_command_shaper.sv =====
// Drive command shaper: arcade/tank mixer with curve, gain and slew limit.
//
// Input stream (s_axis): one transfer carries both joystick axes.
// Output stream (m_axis): one transfer per input, the left and right motor
// commands, which the block also keeps as the reference for the next slew.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at the
// clock edge; change it only while no item is in flight.
//
// Timing: an item runs through one shared 17x17 multiplier under a small
// sequencer, five steps per axis for the curve and three for gain and clamp,
// then one slew step. The result becomes valid with tready back high in that
// same cycle; no new input is taken until the current result is loaded.
// A pending result does not block the next input transfer; if the receiver
// still holds off tready when the next result is ready, the sequencer waits
// in its slew step and the commands stay unchanged.
// Reset (synchronous, active low) restores the default registers, clears
// both held commands to zero and empties the output.
module drive_command_shaper (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // stick_a [7:0], stick_b [15:8]
    input  logic [dcs_pkg::TDATA_W-1:0]        i_s_axis_tdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // left_cmd [7:0], right_cmd [15:8]
    output logic [dcs_pkg::TDATA_W-1:0]        o_m_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic                               i_cfg_we,
    input  logic [dcs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dcs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dcs_pkg::*;

    // Configuration registers
    logic       r_drive_mode;
    logic [6:0] r_deadzone;
    logic       r_curve_en;
    logic [8:0] r_curve_blend;
    logic [9:0] r_sens;
    logic [6:0] r_rev_band;
    logic [7:0] r_slew_step;
    logic       r_stop_rev;

    // Sequencer
    t_state r_state, n_state;
    logic   r_axis, n_axis;
    logic   r_out_valid, n_out_valid;

    // Datapath
    logic signed [7:0] r_va, r_vb;
    logic [14:0]       r_x;
    logic              r_neg;
    logic signed [8:0] r_ca, r_cb;
    logic signed [7:0] r_tgt_l, r_tgt_r;
    logic signed [7:0] r_last_l, r_last_r;

    logic                     in_xfer;
    logic                     load_out;
    t_mul_req                 mul_req;
    logic signed [PROD_W-1:0] prod;
    t_slew_cfg                slew_cfg;
    logic signed [7:0]        slew_l, slew_r;

    logic signed [7:0]  raw_a, raw_b;
    logic [7:0]         mag_a, mag_b;
    logic signed [7:0]  v;
    logic [7:0]         v_mag;
    logic signed [8:0]  curve_fac;
    logic signed [23:0] v_ext;
    logic signed [23:0] num;
    logic [23:0]        num_mag;
    logic [8:0]         q0;
    logic [15:0]        rem;
    logic [8:0]         q;
    logic signed [8:0]  c_curve;
    logic signed [8:0]  c_sel;
    logic signed [9:0]  mix_l, mix_r;
    logic [19:0]        p_mag;
    logic [11:0]        p_shr;
    logic [6:0]         sat;
    logic signed [7:0]  gain_cmd;

    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // Deadzone on the incoming axes
    assign raw_a = i_s_axis_tdata[7:0];
    assign raw_b = i_s_axis_tdata[15:8];
    assign mag_a = raw_a[7] ? (~raw_a + 8'd1) : raw_a;
    assign mag_b = raw_b[7] ? (~raw_b + 8'd1) : raw_b;

    // Curve: v*(|v|-127), times blend, plus v*32512, then divide by 32512
    assign v         = r_axis ? r_vb : r_va;
    assign v_mag     = v[7] ? (~v + 8'd1) : v;
    assign curve_fac = $signed({1'b0, v_mag}) - 9'sd127;
    assign v_ext     = 24'(v);
    assign num       = (v_ext <<< 15) - (v_ext <<< 8) + $signed(prod[23:0]);
    assign num_mag   = num[23] ? 24'(-num) : 24'(num);

    // Quotient by 127 from the reciprocal, one correction step
    assign q0      = prod[24:16];
    assign rem     = {1'b0, r_x} - {q0, 7'b0} + 16'(q0);
    assign q       = (rem >= 16'd127) ? (q0 + 9'd1) : q0;
    assign c_curve = r_neg ? $signed(9'd0 - q) : $signed(q);
    assign c_sel   = (r_curve_en && (v != 8'sd0)) ? c_curve : 9'(v);

    // Mixing
    assign mix_l = r_drive_mode ? 10'(r_ca) : (10'(r_ca) + 10'(r_cb));
    assign mix_r = r_drive_mode ? 10'(r_cb) : (10'(r_ca) - 10'(r_cb));

    // Gain truncation toward zero and clamp, shared by both sides
    assign p_mag    = prod[PROD_W-1] ? 20'(-prod) : 20'(prod);
    assign p_shr    = p_mag[19:8];
    assign sat      = (p_shr > 12'(CMD_MAX)) ? CMD_MAX[6:0] : p_shr[6:0];
    assign gain_cmd = prod[PROD_W-1] ? $signed(8'd0 - {1'b0, sat}) : $signed({1'b0, sat});

    assign slew_cfg = '{band: r_rev_band, step: r_slew_step, stop: r_stop_rev};

    dcs_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .o_prod(prod)
    );

    dcs_slew u_slew_l (
        .i_cfg (slew_cfg),
        .i_cur (r_last_l),
        .i_tgt (r_tgt_l),
        .o_next(slew_l)
    );

    dcs_slew u_slew_r (
        .i_cfg (slew_cfg),
        .i_cur (r_last_r),
        .i_tgt (r_tgt_r),
        .o_next(slew_r)
    );

    // Next state, multiplier operands and handshake
    always_comb begin
        n_state         = r_state;
        n_axis          = r_axis;
        load_out        = 1'b0;
        o_s_axis_tready = 1'b0;
        mul_req.en      = 1'b0;
        mul_req.op_a    = MUL_W'(v);
        mul_req.op_b    = MUL_W'(curve_fac);
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = ST_CRV_P;
                    n_axis  = 1'b0;
                end
            end
            ST_CRV_P: begin
                mul_req.en = 1'b1;
                n_state    = ST_CRV_T;
            end
            ST_CRV_T: begin
                mul_req.en   = 1'b1;
                mul_req.op_a = $signed({8'd0, r_curve_blend});
                mul_req.op_b = $signed(prod[MUL_W-1:0]);
                n_state      = ST_CRV_N;
            end
            ST_CRV_N: begin
                n_state = ST_CRV_Q;
            end
            ST_CRV_Q: begin
                mul_req.en   = 1'b1;
                mul_req.op_a = $signed({2'b00, r_x});
                mul_req.op_b = $signed(RECIP_127);
                n_state      = ST_CRV_C;
            end
            ST_CRV_C: begin
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = ST_CRV_P;
                end else begin
                    n_state = ST_GAIN_L;
                end
            end
            ST_GAIN_L: begin
                mul_req.en   = 1'b1;
                mul_req.op_a = MUL_W'(mix_l);
                mul_req.op_b = $signed({7'd0, r_sens});
                n_state      = ST_GAIN_R;
            end
            ST_GAIN_R: begin
                mul_req.en   = 1'b1;
                mul_req.op_a = MUL_W'(mix_r);
                mul_req.op_b = $signed({7'd0, r_sens});
                n_state      = ST_CLAMP_R;
            end
            ST_CLAMP_R: begin
                n_state = ST_SLEW;
            end
            ST_SLEW: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on a new result, cleared once the transfer completes
    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_axis        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_last_l      <= '0;
            r_last_r      <= '0;
            r_drive_mode  <= RST_DRIVE_MODE;
            r_deadzone    <= RST_DEADZONE;
            r_curve_en    <= RST_CURVE_EN;
            r_curve_blend <= RST_CURVE_BLEND;
            r_sens        <= RST_SENS;
            r_rev_band    <= RST_REV_BAND;
            r_slew_step   <= RST_SLEW_STEP;
            r_stop_rev    <= RST_STOP_REV;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
            if (load_out) begin
                r_last_l <= slew_l;
                r_last_r <= slew_r;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DRIVE_MODE:   r_drive_mode  <= i_cfg_data[0];
                    REG_DEADZONE:     r_deadzone    <= i_cfg_data[6:0];
                    REG_CURVE_ENABLE: r_curve_en    <= i_cfg_data[0];
                    REG_CURVE_BLEND:  r_curve_blend <= i_cfg_data[8:0];
                    REG_SENSITIVITY:  r_sens        <= i_cfg_data[9:0];
                    REG_REV_BAND:     r_rev_band    <= i_cfg_data[6:0];
                    REG_SLEW_STEP:    r_slew_step   <= i_cfg_data[7:0];
                    REG_STOP_ON_REV:  r_stop_rev    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_va <= (mag_a < {1'b0, r_deadzone}) ? 8'sd0 : raw_a;
            r_vb <= (mag_b < {1'b0, r_deadzone}) ? 8'sd0 : raw_b;
        end
        if (r_state == ST_CRV_N) begin
            r_x   <= num_mag[22:8];
            r_neg <= num[23];
        end
        if (r_state == ST_CRV_C) begin
            if (r_axis) begin
                r_cb <= c_sel;
            end else begin
                r_ca <= c_sel;
            end
        end
        if (r_state == ST_GAIN_R) begin
            r_tgt_l <= gain_cmd;
        end
        if (r_state == ST_CLAMP_R) begin
            r_tgt_r <= gain_cmd;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_last_r, r_last_l};

endmodule

// ===== tb/drive_command_shaper_test.sv =====
module drive_command_shaper_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dcs_pkg::*;

    // Register image held alongside the block
    typedef struct {
        bit       tank;
        bit [6:0] deadzone;
        bit       curve_on;
        bit [8:0] blend;
        bit [9:0] gain;
        bit [6:0] band;
        bit [7:0] step;
        bit       stop_rev;
    } t_shaper_regs;

    typedef struct {
        logic signed [7:0] left;
        logic signed [7:0] right;
    } t_cmd_pair;

    localparam logic signed [7:0] STICK_MAX = 8'sd127;
    localparam logic signed [7:0] STICK_MIN = 8'sh80;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic [TDATA_W-1:0]    i_s_axis_tdata = '0;     // stick_a [7:0], stick_b [15:8]
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [TDATA_W-1:0]    o_m_axis_tdata;          // left_cmd [7:0], right_cmd [15:8]
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b1;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_shaper_regs shaper_regs;
    longint       held_left;
    longint       held_right;
    t_cmd_pair    pending_cmds[$];
    t_cmd_pair    due_cmds;
    int           mismatch_count = 0;

    // Sender and receiver pacing
    bit tx_gappy = 1'b0;
    int tx_burst_left = 0;
    bit rx_stalls_on = 1'b0;
    bit rx_ready_now = 1'b1;
    int rx_run_left = 0;

    drive_command_shaper uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint mag(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Deadzone, then blended square curve, truncated once toward zero
    function automatic longint shape_stick(input logic signed [7:0] raw);
        longint v;
        v = raw;
        if (mag(v) < longint'(shaper_regs.deadzone))
            v = 0;
        if (shaper_regs.curve_on && v != 0)
            v = (v * 32512 + longint'(shaper_regs.blend) * (v * mag(v) - 127 * v)) / 32512;
        return v;
    endfunction

    function automatic longint gain_limit(input longint x);
        longint g;
        g = (x * longint'(shaper_regs.gain)) / 256;
        if (g > 127)
            g = 127;
        if (g < -127)
            g = -127;
        return g;
    endfunction

    // Slew limit with forced ramp toward zero on a reversal
    function automatic longint slew_towards(input longint cur, input longint tgt);
        longint delta;
        longint band;
        longint stp;
        longint st;
        bit     rev;
        delta = tgt - cur;
        band  = shaper_regs.band;
        stp   = shaper_regs.step;
        rev   = (cur > band && tgt < -band) || (cur < -band && tgt > band);
        if (mag(delta) <= 1)
            return tgt;
        if (rev && shaper_regs.stop_rev) begin
            st = (stp < mag(cur)) ? stp : mag(cur);
            return (cur > 0) ? cur - st : cur + st;
        end
        if (mag(delta) <= stp)
            return tgt;
        return cur + ((delta > 0) ? stp : -stp);
    endfunction

    function automatic t_cmd_pair predict_cmds(input logic signed [7:0] a,
                                               input logic signed [7:0] b);
        longint    sa;
        longint    sb;
        longint    l;
        longint    r;
        t_cmd_pair res;
        sa = shape_stick(a);
        sb = shape_stick(b);
        if (shaper_regs.tank) begin
            l = sa;
            r = sb;
        end else begin
            l = sa + sb;
            r = sa - sb;
        end
        held_left  = slew_towards(held_left, gain_limit(l));
        held_right = slew_towards(held_right, gain_limit(r));
        res.left   = held_left[7:0];
        res.right  = held_right[7:0];
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t ns %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Result side: compare each transfer, then pick the next stall pattern step
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_cmds.size() == 0) begin
                report_mismatch("result with nothing pending", o_m_axis_tdata, 0);
            end else begin
                due_cmds = pending_cmds.pop_front();
                if ($signed(o_m_axis_tdata[7:0]) !== due_cmds.left)
                    report_mismatch("left_cmd", $signed(o_m_axis_tdata[7:0]),
                                    due_cmds.left);
                if ($signed(o_m_axis_tdata[15:8]) !== due_cmds.right)
                    report_mismatch("right_cmd", $signed(o_m_axis_tdata[15:8]),
                                    due_cmds.right);
            end
        end
        if (rx_run_left == 0) begin
            rx_ready_now = !rx_ready_now || !rx_stalls_on;
            rx_run_left  = rx_ready_now ? $urandom_range(1, 20) : $urandom_range(1, 25);
        end else begin
            rx_run_left--;
        end
        i_m_axis_tready <= rx_ready_now;
    end

    // ---------------------------------------------------------------- stimulus

    // One input transfer; tvalid is left high so back-to-back items need no dip
    task automatic send_sticks(input logic signed [7:0] a, input logic signed [7:0] b);
        if (tx_gappy && tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 10);
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
        if (tx_burst_left != 0)
            tx_burst_left--;
        i_s_axis_tdata  <= {b, a};
        i_s_axis_tvalid <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        pending_cmds.push_back(predict_cmds(a, b));
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic put_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Write every register; only called with nothing in flight
    task automatic load_settings(input t_shaper_regs c);
        shaper_regs = c;
        put_reg(REG_DRIVE_MODE,   CFG_DATA_W'(c.tank));
        put_reg(REG_DEADZONE,     CFG_DATA_W'(c.deadzone));
        put_reg(REG_CURVE_ENABLE, CFG_DATA_W'(c.curve_on));
        put_reg(REG_CURVE_BLEND,  CFG_DATA_W'(c.blend));
        put_reg(REG_SENSITIVITY,  CFG_DATA_W'(c.gain));
        put_reg(REG_REV_BAND,     CFG_DATA_W'(c.band));
        put_reg(REG_SLEW_STEP,    CFG_DATA_W'(c.step));
        put_reg(REG_STOP_ON_REV,  CFG_DATA_W'(c.stop_rev));
        i_cfg_we <= 1'b0;
    endtask

    // Biased stick value: extremes, values around the deadzone, or anything
    function automatic logic signed [7:0] any_stick();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) != 0) ? STICK_MAX : STICK_MIN;
            1:       return -STICK_MAX;
            2, 3:    return 8'($urandom_range(0, 24)) - 8'sd12;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_shaper_regs random_settings();
        t_shaper_regs c;
        c.tank     = 1'($urandom_range(0, 1));
        c.curve_on = $urandom_range(0, 3) != 0;
        c.stop_rev = $urandom_range(0, 3) != 0;
        case ($urandom_range(0, 5))
            0:       c.deadzone = 7'd0;
            1:       c.deadzone = 7'd127;
            default: c.deadzone = 7'($urandom_range(0, 20));
        endcase
        case ($urandom_range(0, 6))
            0:       c.blend = 9'd0;
            1:       c.blend = 9'd256;
            2:       c.blend = 9'd511;
            default: c.blend = 9'($urandom_range(0, 300));
        endcase
        case ($urandom_range(0, 7))
            0:       c.gain = 10'd0;
            1:       c.gain = 10'd256;
            2:       c.gain = 10'd512;
            3:       c.gain = 10'd1023;
            default: c.gain = 10'($urandom_range(100, 600));
        endcase
        case ($urandom_range(0, 6))
            0:       c.band = 7'd0;
            1:       c.band = 7'd127;
            default: c.band = 7'($urandom_range(0, 40));
        endcase
        case ($urandom_range(0, 8))
            0:       c.step = 8'd0;
            1:       c.step = 8'd1;
            2:       c.step = 8'd254;
            3:       c.step = 8'd255;
            default: c.step = 8'($urandom_range(2, 40));
        endcase
        return c;
    endfunction

    // ---------------------------------------------------------------- tests

    // Reset values: deadzone 5, full curve, unity gain, step 15, stop on reversal
    task automatic test_reset_defaults();
        send_sticks(STICK_MAX, 8'sd0);
        send_sticks(STICK_MAX, 8'sd0);
        send_sticks(-STICK_MAX, 8'sd0);
        send_sticks(STICK_MIN, STICK_MIN);
        send_sticks(8'sd0, STICK_MAX);
        send_sticks(8'sd3, -8'sd4);
        send_sticks(8'sd0, 8'sd0);
        drain_results();
    endtask

    task automatic test_register_extremes();
        // Tank, linear, zero step: small changes pass, larger ones hold
        load_settings('{1'b1, 7'd0, 1'b0, 9'd511, 10'd256, 7'd0, 8'd0, 1'b1});
        send_sticks(8'sd1, -8'sd1);
        send_sticks(STICK_MAX, STICK_MIN);
        send_sticks(8'sd2, -8'sd2);
        drain_results();
        // Arcade, widest deadzone, over-unity blend, huge gain, full step
        load_settings('{1'b0, 7'd127, 1'b1, 9'd511, 10'd1023, 7'd127, 8'd255, 1'b0});
        send_sticks(STICK_MAX, 8'sd0);
        send_sticks(8'sd126, STICK_MIN);
        send_sticks(STICK_MIN, STICK_MAX);
        drain_results();
        // Zero gain, unit step
        load_settings('{1'b0, 7'd0, 1'b1, 9'd0, 10'd0, 7'd0, 8'd1, 1'b1});
        send_sticks(STICK_MAX, STICK_MAX);
        send_sticks(STICK_MIN, STICK_MIN);
        drain_results();
        // Double gain, near-full step, reversal without the stop ramp
        load_settings('{1'b0, 7'd0, 1'b0, 9'd256, 10'd512, 7'd0, 8'd254, 1'b0});
        send_sticks(STICK_MAX, STICK_MAX);
        send_sticks(-STICK_MAX, STICK_MAX);
        send_sticks(STICK_MAX, STICK_MIN);
        send_sticks(STICK_MIN, STICK_MIN);
        drain_results();
    endtask

    // Held sticks let commands ramp and reverse; the rest is noise
    task automatic test_random_phase(input int n_items);
        int                sent;
        int                hold;
        logic signed [7:0] a;
        logic signed [7:0] b;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                send_sticks(any_stick(), any_stick());
                sent++;
            end else begin
                a    = any_stick();
                b    = any_stick();
                hold = $urandom_range(2, 14);
                repeat (hold) begin
                    send_sticks(a, b);
                    sent++;
                end
                if ($urandom_range(0, 1) != 0) begin
                    a = -a;
                    if ($urandom_range(0, 1) != 0)
                        b = -b;
                    repeat (hold) begin
                        send_sticks(a, b);
                        sent++;
                    end
                end
            end
        end
    endtask

    task automatic test_random_settings();
        repeat (9) begin
            load_settings(random_settings());
            tx_gappy     = $urandom_range(0, 3) != 0;
            rx_stalls_on = $urandom_range(0, 3) != 0;
            test_random_phase(150);
            drain_results();
        end
    endtask

    // ---------------------------------------------------------------- run

    initial begin
        shaper_regs = '{1'b0, 7'd5, 1'b1, 9'd256, 10'd256, 7'd10, 8'd15, 1'b1};
        held_left   = 0;
        held_right  = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_gappy     = 1'b1;
        rx_stalls_on = 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_random_settings();
        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("drive_command_shaper: match");
        else
            $display("drive_command_shaper: mismatch");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial begin
        #2000000;
        $display("drive_command_shaper: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dcs_pkg.sv
rtl/dcs_mul.sv
rtl/dcs_slew.sv
rtl/drive_command_shaper.sv
tb/drive_command_shaper_test.sv
